FILE: hw/rtl/xlsf_pkg.sv
// Shared types and constants for the x86 logic/shift flag unit.
// Holds the beat structs, operation and condition codes, and flag bit positions.
// Depends on nothing.
package xlsf_pkg;

  // Operation codes of the input beat
  typedef enum logic [3:0] {
    OP_TEST  = 4'd0,
    OP_AND   = 4'd1,
    OP_XOR   = 4'd2,
    OP_OR    = 4'd3,
    OP_SAR   = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_SETCC = 4'd7,
    OP_NOT   = 4'd8
  } op_t;

  // Condition groups: upper three bits of the x86 condition code
  typedef enum logic [2:0] {
    COND_O  = 3'd0,
    COND_B  = 3'd1,
    COND_E  = 3'd2,
    COND_BE = 3'd3,
    COND_S  = 3'd4,
    COND_P  = 3'd5,
    COND_L  = 3'd6,
    COND_LE = 3'd7
  } cond_t;

  // Flag bit positions in flags_in / flags_out
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_ZF = 1;
  localparam int unsigned FLAG_SF = 2;
  localparam int unsigned FLAG_OF = 3;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned CNT_W   = 5;

  // Operand widths in bytes with their own mask; anything else acts as 4 bytes
  localparam logic [2:0] WIDTH_BYTE = 3'd1;
  localparam logic [2:0] WIDTH_WORD = 3'd2;

  typedef struct packed {
    logic [3:0]         operation;
    logic [2:0]         width_bytes;
    logic [DATA_W-1:0]  dest_value;
    logic [DATA_W-1:0]  src_value;
    logic [3:0]         cond_code;
    logic [FLAGS_W-1:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result_value;
    logic               write_back;
    logic [FLAGS_W-1:0] flags_out;
  } out_item_t;

endpackage

FILE: hw/rtl/xlsf_cond_eval.sv
// Condition evaluator for SETcc: decodes an x86 condition code against the flags.
// Depends on xlsf_pkg.
module xlsf_cond_eval (
  input  logic [3:0]                  cond_code,
  input  logic [xlsf_pkg::FLAGS_W-1:0] flags,
  output logic                        taken
);

  logic cf;
  logic zf;
  logic sf;
  logic of;
  logic base;
  logic valid_cond;

  assign cf = flags[xlsf_pkg::FLAG_CF];
  assign zf = flags[xlsf_pkg::FLAG_ZF];
  assign sf = flags[xlsf_pkg::FLAG_SF];
  assign of = flags[xlsf_pkg::FLAG_OF];

  // Pick the base condition; parity is not tracked, so both parity codes give 0
  always_comb begin
    valid_cond = 1'b1;
    case (xlsf_pkg::cond_t'(cond_code[3:1]))
      xlsf_pkg::COND_O:  base = of;
      xlsf_pkg::COND_B:  base = cf;
      xlsf_pkg::COND_E:  base = zf;
      xlsf_pkg::COND_BE: base = cf | zf;
      xlsf_pkg::COND_S:  base = sf;
      xlsf_pkg::COND_P: begin
        base       = 1'b0;
        valid_cond = 1'b0;
      end
      xlsf_pkg::COND_L:  base = sf ^ of;
      xlsf_pkg::COND_LE: base = zf | (sf ^ of);
      default:           base = 1'b0;
    endcase
  end

  // Low bit of the code negates
  assign taken = valid_cond & (base ^ cond_code[0]);

endmodule

FILE: hw/rtl/xlsf_exec.sv
// Combinational execute logic: bitwise ops, shifts, SETcc and NOT with flag update.
// Depends on xlsf_pkg and xlsf_cond_eval.
module xlsf_exec (
  input  xlsf_pkg::in_item_t  item,
  output xlsf_pkg::out_item_t res
);

  logic [xlsf_pkg::DATA_W-1:0]  mask;
  logic [xlsf_pkg::DATA_W-1:0]  sign;
  logic [xlsf_pkg::DATA_W-1:0]  d;
  logic [xlsf_pkg::DATA_W-1:0]  s;
  logic [xlsf_pkg::DATA_W-1:0]  d_sext;
  logic [xlsf_pkg::DATA_W-1:0]  r;
  logic [xlsf_pkg::CNT_W-1:0]   cnt;
  logic [xlsf_pkg::FLAGS_W-1:0] zs_flags;
  logic [xlsf_pkg::FLAGS_W-1:0] keep_co;
  logic [xlsf_pkg::FLAGS_W-1:0] fo;
  logic                         wr;
  logic                         cond_taken;

  // Width mask and sign bit
  always_comb begin
    case (item.width_bytes)
      xlsf_pkg::WIDTH_BYTE: begin
        mask = 32'h0000_00FF;
        sign = 32'h0000_0080;
      end
      xlsf_pkg::WIDTH_WORD: begin
        mask = 32'h0000_FFFF;
        sign = 32'h0000_8000;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        sign = 32'h8000_0000;
      end
    endcase
  end

  assign d      = item.dest_value & mask;
  assign s      = item.src_value;
  assign cnt    = item.src_value[xlsf_pkg::CNT_W-1:0];
  assign d_sext = ((d & sign) != '0) ? (d | ~mask) : d;

  xlsf_cond_eval u_cond (
    .cond_code (item.cond_code),
    .flags     (item.flags_in),
    .taken     (cond_taken)
  );

  // Result and write-back select
  always_comb begin
    wr = 1'b1;
    case (xlsf_pkg::op_t'(item.operation))
      xlsf_pkg::OP_TEST: begin
        r  = d & s;
        wr = 1'b0;
      end
      xlsf_pkg::OP_AND:   r = d & s;
      xlsf_pkg::OP_XOR:   r = (d ^ s) & mask;
      xlsf_pkg::OP_OR:    r = (d | s) & mask;
      xlsf_pkg::OP_SAR:   r = 32'($signed(d_sext) >>> cnt) & mask;
      xlsf_pkg::OP_SHL:   r = (d << cnt) & mask;
      xlsf_pkg::OP_SHR:   r = d >> cnt;
      xlsf_pkg::OP_SETCC: r = {{(xlsf_pkg::DATA_W-1){1'b0}}, cond_taken};
      xlsf_pkg::OP_NOT:   r = ~d & mask;
      default: begin
        r  = d;
        wr = 1'b0;
      end
    endcase
  end

  // ZF and SF from the result at the operand width
  always_comb begin
    zs_flags = '0;
    zs_flags[xlsf_pkg::FLAG_ZF] = (r == '0);
    zs_flags[xlsf_pkg::FLAG_SF] = ((r & sign) != '0);
    keep_co = '0;
    keep_co[xlsf_pkg::FLAG_CF] = item.flags_in[xlsf_pkg::FLAG_CF];
    keep_co[xlsf_pkg::FLAG_OF] = item.flags_in[xlsf_pkg::FLAG_OF];
  end

  // Flag update: logic ops clear CF/OF, shifts keep them, the rest pass through
  always_comb begin
    case (xlsf_pkg::op_t'(item.operation))
      xlsf_pkg::OP_TEST,
      xlsf_pkg::OP_AND,
      xlsf_pkg::OP_XOR,
      xlsf_pkg::OP_OR:  fo = zs_flags;
      xlsf_pkg::OP_SAR,
      xlsf_pkg::OP_SHL,
      xlsf_pkg::OP_SHR: fo = keep_co | zs_flags;
      default:          fo = item.flags_in;
    endcase
  end

  assign res.result_value = r;
  assign res.write_back   = wr;
  assign res.flags_out    = fo;

endmodule

FILE: hw/rtl/x86_logic_shift_flag_unit_top.sv
// x86 logic/shift flag unit: input register, execute logic, result register.
// One beat in and one beat out each cycle while out_stall is low; each beat
// passes through the input register, then the result register. Each stage holds
// one instruction. While the result register waits downstream, the input register
// still takes a beat if it is empty; once both stages are full, the input stalls.
// With no downstream stall the unit sustains one instruction per clock. Stall
// back-pressure passes through both registers in the same cycle. No configuration
// and no state beyond the stage registers. Depends on xlsf_pkg and xlsf_exec.
module x86_logic_shift_flag_unit_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  xlsf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xlsf_pkg::out_item_t out_data
);

  logic                s1_valid;
  xlsf_pkg::in_item_t  s1_item;
  xlsf_pkg::out_item_t exec_res;
  logic                out_free;
  logic                s1_free;

  // A stage may load when it is empty or its content moves on this cycle
  assign out_free = ~out_valid | ~out_stall;
  assign s1_free  = ~s1_valid | out_free;
  assign in_stall = ~s1_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item <= in_data;
    end
  end

  xlsf_exec u_exec (
    .item (s1_item),
    .res  (exec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= exec_res;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for x86_logic_shift_flag_unit_top: logic, shift, setcc and not.
// Predicts each result beat in SystemVerilog and compares it to the DUT under random idling.
// Depends on xlsf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef enum int {IDLE_MIXED, IDLE_NONE, IDLE_HEAVY} idle_mode_t;

  localparam logic [3:0] OP_UNUSED_LAST = 4'd15;
  localparam logic [2:0] WIDTH_DWORD    = 3'd4;
  localparam logic [2:0] WIDTH_ODD_ZERO = 3'd0;
  localparam logic [2:0] WIDTH_ODD_TOP  = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  xlsf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  xlsf_pkg::out_item_t out_data;

  xlsf_pkg::out_item_t expected_results[$];
  int                  mismatch_count = 0;
  idle_mode_t          idle_mode = IDLE_MIXED;
  int                  stall_run = 0;

  x86_logic_shift_flag_unit_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [3:0] zero_sign_flags(logic [31:0] r, logic [31:0] sign);
    logic [3:0] f;
    f = '0;
    f[xlsf_pkg::FLAG_ZF] = (r == '0);
    f[xlsf_pkg::FLAG_SF] = |(r & sign);
    return f;
  endfunction

  function automatic logic cond_holds(logic [3:0] cc, logic [3:0] fl);
    logic c_f, z_f, s_f, o_f, t;
    c_f = fl[xlsf_pkg::FLAG_CF];
    z_f = fl[xlsf_pkg::FLAG_ZF];
    s_f = fl[xlsf_pkg::FLAG_SF];
    o_f = fl[xlsf_pkg::FLAG_OF];
    case (xlsf_pkg::cond_t'(cc[3:1]))
      xlsf_pkg::COND_O:  t = o_f;
      xlsf_pkg::COND_B:  t = c_f;
      xlsf_pkg::COND_E:  t = z_f;
      xlsf_pkg::COND_BE: t = c_f | z_f;
      xlsf_pkg::COND_S:  t = s_f;
      // parity is not tracked: false for both senses
      xlsf_pkg::COND_P:  return 1'b0;
      xlsf_pkg::COND_L:  t = s_f ^ o_f;
      default:           t = z_f | (s_f ^ o_f);
    endcase
    return cc[0] ? ~t : t;
  endfunction

  function automatic xlsf_pkg::out_item_t exec_logic_shift(xlsf_pkg::in_item_t it);
    xlsf_pkg::out_item_t        res;
    logic [31:0]                mask, sign, d, s, r;
    logic signed [31:0]         xs;
    logic [xlsf_pkg::CNT_W-1:0] cnt;
    logic [3:0]                 keep_co;
    case (it.width_bytes)
      xlsf_pkg::WIDTH_BYTE: mask = 32'h0000_00ff;
      xlsf_pkg::WIDTH_WORD: mask = 32'h0000_ffff;
      default:              mask = 32'hffff_ffff;
    endcase
    sign = mask ^ (mask >> 1);
    d    = it.dest_value & mask;
    s    = it.src_value;
    cnt  = s[xlsf_pkg::CNT_W-1:0];
    keep_co = '0;
    keep_co[xlsf_pkg::FLAG_CF] = it.flags_in[xlsf_pkg::FLAG_CF];
    keep_co[xlsf_pkg::FLAG_OF] = it.flags_in[xlsf_pkg::FLAG_OF];
    res.write_back = 1'b1;
    res.flags_out  = it.flags_in;
    case (it.operation)
      xlsf_pkg::OP_TEST, xlsf_pkg::OP_AND, xlsf_pkg::OP_XOR, xlsf_pkg::OP_OR: begin
        case (it.operation)
          xlsf_pkg::OP_XOR: r = (d ^ s) & mask;
          xlsf_pkg::OP_OR:  r = (d | s) & mask;
          default:          r = d & s & mask;
        endcase
        res.write_back = (it.operation != xlsf_pkg::OP_TEST);
        res.flags_out  = zero_sign_flags(r, sign);
      end
      xlsf_pkg::OP_SAR, xlsf_pkg::OP_SHL, xlsf_pkg::OP_SHR: begin
        case (it.operation)
          xlsf_pkg::OP_SAR: begin
            // sign-extend from the operand width before the arithmetic shift
            xs = d;
            if (|(d & sign)) xs = xs | ~mask;
            r = 32'(xs >>> cnt) & mask;
          end
          xlsf_pkg::OP_SHL: r = (d << cnt) & mask;
          default:          r = (d >> cnt) & mask;
        endcase
        res.flags_out = keep_co | zero_sign_flags(r, sign);
      end
      xlsf_pkg::OP_SETCC: r = {31'b0, cond_holds(it.cond_code, it.flags_in)};
      xlsf_pkg::OP_NOT:   r = ~d & mask;
      default: begin
        r = d;
        res.write_back = 1'b0;
      end
    endcase
    res.result_value = r;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    xlsf_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_data.result_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch("result_value", out_data.result_value, want.result_value);
        if (out_data.write_back !== want.write_back)
          report_mismatch("write_back", 32'(out_data.write_back), 32'(want.write_back));
        if (out_data.flags_out !== want.flags_out)
          report_mismatch("flags_out", 32'(out_data.flags_out), 32'(want.flags_out));
      end
    end
  end

  // ---------------------------------------------------------------- idling

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == IDLE_NONE) return 0;
    if (idle_mode == IDLE_HEAVY) begin
      if (r < 30) return 0;
      if (r < 80) return $urandom_range(1, 4);
      return $urandom_range(5, 24);
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Hold back results in random runs of stall
  always @(posedge clk) begin
    if (idle_mode == IDLE_NONE) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < ((idle_mode == IDLE_HEAVY) ? 40 : 15)) begin
      stall_run = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic xlsf_pkg::in_item_t make_item(logic [3:0] op, logic [2:0] wb,
                                                   logic [31:0] d, logic [31:0] s,
                                                   logic [3:0] cc, logic [3:0] fl);
    xlsf_pkg::in_item_t it;
    it.operation   = op;
    it.width_bytes = wb;
    it.dest_value  = d;
    it.src_value   = s;
    it.cond_code   = cc;
    it.flags_in    = fl;
    return it;
  endfunction

  // Drive one beat, record its prediction once taken, then idle for a random gap
  task automatic send_beat(input xlsf_pkg::in_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(exec_logic_shift(it));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_bitwise_flags();
    // source bits above the width are masked away, so TEST gives zero
    send_beat(make_item(xlsf_pkg::OP_TEST, xlsf_pkg::WIDTH_BYTE, 32'hffff_ffff,
                        32'hffff_ff00, 4'h0, 4'hf));
    send_beat(make_item(xlsf_pkg::OP_AND, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffff,
                        4'h0, 4'hf));
    send_beat(make_item(xlsf_pkg::OP_AND, xlsf_pkg::WIDTH_WORD, 32'h1234_8001,
                        32'hffff_0000, 4'h0, 4'h9));
    send_beat(make_item(xlsf_pkg::OP_XOR, xlsf_pkg::WIDTH_WORD, 32'h0000_a5a5,
                        32'hffff_a5a5, 4'h0, 4'h0));
    send_beat(make_item(xlsf_pkg::OP_OR, xlsf_pkg::WIDTH_BYTE, 32'h0000_0000,
                        32'h0000_0080, 4'h0, 4'h9));
  endtask

  task automatic test_shift_counts();
    send_beat(make_item(xlsf_pkg::OP_SAR, xlsf_pkg::WIDTH_BYTE, 32'h0000_0080,
                        32'h0000_0007, 4'h0, 4'h0));
    // a count of zero still sets ZF and SF from the operand
    send_beat(make_item(xlsf_pkg::OP_SAR, xlsf_pkg::WIDTH_WORD, 32'hffff_7fff,
                        32'h0000_0000, 4'h0, 4'hf));
    send_beat(make_item(xlsf_pkg::OP_SHL, WIDTH_DWORD, 32'h0000_0001, 32'h0000_001f,
                        4'h0, 4'h1));
    send_beat(make_item(xlsf_pkg::OP_SHR, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffe0,
                        4'h0, 4'h8));
    send_beat(make_item(xlsf_pkg::OP_SHL, xlsf_pkg::WIDTH_BYTE, 32'h0000_00ff,
                        32'h0000_0008, 4'h0, 4'h6));
    send_beat(make_item(xlsf_pkg::OP_SAR, WIDTH_DWORD, 32'h8000_0000, 32'hffff_ffff,
                        4'h0, 4'h9));
  endtask

  task automatic test_setcc_conditions();
    // one beat per condition code, both senses; parity falls in here too
    for (int c = 0; c < 16; c++) begin
      send_beat(make_item(xlsf_pkg::OP_SETCC, WIDTH_DWORD, $urandom, $urandom,
                          4'(c), 4'($urandom)));
    end
  endtask

  task automatic test_not_odd_unused();
    send_beat(make_item(xlsf_pkg::OP_NOT, xlsf_pkg::WIDTH_BYTE, 32'h1234_5600, 32'h0,
                        4'h0, 4'h5));
    send_beat(make_item(xlsf_pkg::OP_NOT, WIDTH_DWORD, 32'h0000_0000, 32'h0, 4'h0, 4'ha));
    send_beat(make_item(OP_UNUSED_LAST, xlsf_pkg::WIDTH_BYTE, 32'hdead_beef, 32'h0,
                        4'h0, 4'h7));
    // widths outside 1 and 2 act as four bytes
    send_beat(make_item(xlsf_pkg::OP_XOR, WIDTH_ODD_ZERO, 32'h8000_0000, 32'h0000_0001,
                        4'h0, 4'h0));
    send_beat(make_item(xlsf_pkg::OP_SHR, WIDTH_ODD_TOP, 32'h8000_0000, 32'h0000_0004,
                        4'h0, 4'hf));
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'h80 << (8 * $urandom_range(0, 3));
      3:       return 32'h7f << (8 * $urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_mix(input int count, input idle_mode_t mode);
    logic [2:0]         widths[3];
    xlsf_pkg::in_item_t it;
    widths = '{xlsf_pkg::WIDTH_BYTE, xlsf_pkg::WIDTH_WORD, WIDTH_DWORD};
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 90)
        it.operation = 4'($urandom_range(xlsf_pkg::OP_TEST, xlsf_pkg::OP_NOT));
      else
        it.operation = 4'($urandom_range(int'(xlsf_pkg::OP_NOT) + 1, OP_UNUSED_LAST));
      if ($urandom_range(0, 99) < 85) it.width_bytes = widths[$urandom_range(0, 2)];
      else it.width_bytes = 3'($urandom_range(WIDTH_ODD_ZERO, WIDTH_ODD_TOP));
      it.dest_value = pick_operand();
      it.src_value  = pick_operand();
      // shifts often use counts at the width edges
      if (it.operation inside {xlsf_pkg::OP_SAR, xlsf_pkg::OP_SHL, xlsf_pkg::OP_SHR} &&
          $urandom_range(0, 2) == 0)
        it.src_value[xlsf_pkg::CNT_W-1:0] =
          5'(8 * $urandom_range(0, 3) + $urandom_range(0, 1) - 1);
      it.cond_code = 4'($urandom);
      it.flags_in  = 4'($urandom);
      send_beat(it);
    end
    wait_drained();
    idle_mode = IDLE_MIXED;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_bitwise_flags();
    test_shift_counts();
    wait_drained();
    test_setcc_conditions();
    test_not_odd_unused();
    wait_drained();
    test_random_mix(300, IDLE_MIXED);
    test_random_mix(250, IDLE_NONE);
    test_random_mix(300, IDLE_HEAVY);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Give up long after the slowest legal run would have finished
  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
